// ----- hdl/shfp_pkg.sv -----
package shfp_pkg;

    localparam logic [7:0]  SYNC_BYTE       = 8'h7E;
    localparam logic [2:0]  SYNC_RUN_LAST   = 3'd3;
    localparam logic [15:0] MAX_LEN_DEFAULT = 16'd1024;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ID   = 3'd1,
        PH_NAME = 3'd2,
        PH_TYPE = 3'd3,
        PH_RSVD = 3'd4,
        PH_LENH = 3'd5,
        PH_LENL = 3'd6,
        PH_BODY = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_TYPE    = 3'd2,
        KIND_LENGTH  = 3'd3,
        KIND_BODY    = 3'd4,
        KIND_LEN_ERR = 3'd5
    } item_kind_t;

    // one parsed result on its way to the output register
    typedef struct packed {
        logic        emit;
        item_kind_t  kind;
        logic [15:0] value;
        logic        frame_end;
    } result_t;

endpackage

// ----- hdl/shfp_ifs.sv -----
interface shfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface shfp_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  item_kind;
    logic [15:0] item_value;
    logic        frame_end;

    modport source (output valid, output item_kind, output item_value, output frame_end,
                    input ready);
    modport sink (input valid, input item_kind, input item_value, input frame_end,
                  output ready);
endinterface

interface shfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_body_len;

    modport source (output valid, output max_body_len, input ready);
    modport sink (input valid, input max_body_len, output ready);
endinterface

// ----- hdl/sync_header_frame_parser.sv -----
// a word is held in the input register, and its result then in the output register
// throughput: one word per cycle while the output is taken, set by the combinational
// parser update between the input register and the output register
// reset: rst_n asynchronous active low; parser returns to sync hunt, max body
// length returns to 1024, both valid flags clear
module sync_header_frame_parser
#(
    parameter int ID_BYTES   = 16,
    parameter int NAME_BYTES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    shfp_byte_if.sink     stream,
    shfp_item_if.source   result,
    shfp_cfg_if.sink      cfg
);

    logic                 s1_valid;
    logic [7:0]           s1_byte;
    logic                 advance;
    logic                 out_take;
    logic [15:0]          max_len_reg;
    shfp_pkg::result_t    res;

    // config register, to be written by the user only while the parser is idle; the block does not enforce it
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= shfp_pkg::MAX_LEN_DEFAULT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_len_reg <= cfg.max_body_len;
        end
    end

    // input register, refilled whenever its word moves on
    shfp_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    // phase tracking and result decode; state moves only when the word advances
    shfp_fsm
    #(
        .ID_BYTES   (ID_BYTES),
        .NAME_BYTES (NAME_BYTES)
    )
    u_fsm
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_byte      (s1_byte),
        .out_take     (out_take),
        .max_body_len (max_len_reg),
        .advance      (advance),
        .res          (res)
    );

    // output register; words with no result pass through without a slot
    shfp_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .res      (res),
        .out_take (out_take),
        .result   (result)
    );

endmodule

// ----- hdl/shfp_in_stage.sv -----
module shfp_in_stage
(
    input  logic        clk,
    input  logic        rst_n,
    shfp_byte_if.sink   stream,
    input  logic        advance,
    output logic        s1_valid,
    output logic [7:0]  s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // refill in the same cycle the held word moves on
    assign stream.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (stream.ready)
        begin
            valid_next = stream.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            byte_reg <= stream.data_byte;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule

// ----- hdl/shfp_fsm.sv -----
module shfp_fsm
#(
    parameter int ID_BYTES   = 16,
    parameter int NAME_BYTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s1_valid,
    input  logic [7:0]            s1_byte,
    input  logic                  out_take,
    input  logic [15:0]           max_body_len,
    output logic                  advance,
    output shfp_pkg::result_t     res
);

    localparam logic [15:0] ID_LAST   = 16'(ID_BYTES - 1);
    localparam logic [15:0] NAME_LAST = 16'(NAME_BYTES - 1);

    shfp_pkg::phase_t phase_reg;
    shfp_pkg::phase_t phase_next;
    logic [2:0]       sync_reg;
    logic [2:0]       sync_next;
    logic [15:0]      count_reg;
    logic [15:0]      count_next;
    logic [7:0]       len_hi_reg;
    logic [7:0]       len_hi_next;
    logic [15:0]      length;

    assign advance = s1_valid && out_take;
    assign length  = {len_hi_reg, s1_byte};

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        sync_next   = sync_reg;
        count_next  = count_reg;
        len_hi_next = len_hi_reg;
        case (phase_reg)
            shfp_pkg::PH_HUNT:
            begin
                if (s1_byte == shfp_pkg::SYNC_BYTE)
                begin
                    if (sync_reg == shfp_pkg::SYNC_RUN_LAST)
                    begin
                        sync_next  = 3'd0;
                        count_next = 16'd0;
                        phase_next = shfp_pkg::PH_ID;
                    end
                    else
                    begin
                        sync_next = sync_reg + 3'd1;
                    end
                end
                else
                begin
                    sync_next = 3'd0;
                end
            end
            shfp_pkg::PH_ID:
            begin
                if (count_reg >= ID_LAST)
                begin
                    count_next = 16'd0;
                    phase_next = shfp_pkg::PH_NAME;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            shfp_pkg::PH_NAME:
            begin
                if (count_reg >= NAME_LAST)
                begin
                    count_next = 16'd0;
                    phase_next = shfp_pkg::PH_TYPE;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                end
            end
            shfp_pkg::PH_TYPE:
            begin
                phase_next = shfp_pkg::PH_RSVD;
            end
            shfp_pkg::PH_RSVD:
            begin
                phase_next = shfp_pkg::PH_LENH;
            end
            shfp_pkg::PH_LENH:
            begin
                len_hi_next = s1_byte;
                phase_next  = shfp_pkg::PH_LENL;
            end
            shfp_pkg::PH_LENL:
            begin
                if (length > max_body_len || length == 16'd0)
                begin
                    phase_next = shfp_pkg::PH_HUNT;
                    sync_next  = 3'd0;
                    count_next = 16'd0;
                end
                else
                begin
                    count_next = length;
                    phase_next = shfp_pkg::PH_BODY;
                end
            end
            shfp_pkg::PH_BODY:
            begin
                if (count_reg <= 16'd1)
                begin
                    phase_next = shfp_pkg::PH_HUNT;
                    sync_next  = 3'd0;
                    count_next = 16'd0;
                end
                else
                begin
                    count_next = count_reg - 16'd1;
                end
            end
            default:
            begin
                phase_next = shfp_pkg::PH_HUNT;
            end
        endcase
    end

    // result for the byte in the input register
    always_comb
    begin
        res.emit      = 1'b0;
        res.kind      = shfp_pkg::KIND_ID;
        res.value     = {8'h00, s1_byte};
        res.frame_end = 1'b0;
        case (phase_reg)
            shfp_pkg::PH_ID:
            begin
                res.emit = 1'b1;
                res.kind = shfp_pkg::KIND_ID;
            end
            shfp_pkg::PH_NAME:
            begin
                res.emit = 1'b1;
                res.kind = shfp_pkg::KIND_NAME;
            end
            shfp_pkg::PH_TYPE:
            begin
                res.emit = 1'b1;
                res.kind = shfp_pkg::KIND_TYPE;
            end
            shfp_pkg::PH_LENL:
            begin
                res.emit  = 1'b1;
                res.value = length;
                if (length > max_body_len)
                begin
                    res.kind      = shfp_pkg::KIND_LEN_ERR;
                    res.frame_end = 1'b1;
                end
                else
                begin
                    res.kind      = shfp_pkg::KIND_LENGTH;
                    res.frame_end = (length == 16'd0);
                end
            end
            shfp_pkg::PH_BODY:
            begin
                res.emit      = 1'b1;
                res.kind      = shfp_pkg::KIND_BODY;
                res.frame_end = (count_reg <= 16'd1);
            end
            default:
            begin
                res.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= shfp_pkg::PH_HUNT;
            sync_reg   <= 3'd0;
            count_reg  <= 16'd0;
            len_hi_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            sync_reg   <= sync_next;
            count_reg  <= count_next;
            len_hi_reg <= len_hi_next;
        end
    end

endmodule

// ----- hdl/shfp_out_stage.sv -----
module shfp_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  shfp_pkg::result_t     res,
    output logic                  out_take,
    shfp_item_if.source           result
);

    logic        valid_reg;
    logic        valid_next;
    logic [2:0]  kind_reg;
    logic [15:0] value_reg;
    logic        end_reg;

    assign out_take = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_take)
        begin
            valid_next = advance && res.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            kind_reg  <= res.kind;
            value_reg <= res.value;
            end_reg   <= res.frame_end;
        end
    end

    assign result.valid      = valid_reg;
    assign result.item_kind  = kind_reg;
    assign result.item_value = value_reg;
    assign result.frame_end  = end_reg;

endmodule

// ----- tb/sv/sync_header_frame_parser_tb.sv -----
module sync_header_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ID_BYTES      = 16;
    localparam int          NAME_BYTES    = 16;
    localparam int          SYNC_RUN      = 4;          // sync words that open a frame
    localparam logic [15:0] RESET_MAX_LEN = 16'd1024;
    localparam int          SETTLE_CYCLES = 4;          // settle time after the last result, plus margin
    localparam int          RANDOM_WORDS  = 600;
    localparam int          LONG_BODY_PART = 40;        // body words sent of the longest frame
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    // one result the parser should produce
    typedef struct {
        shfp_pkg::item_kind_t kind;
        logic [15:0]          value;
        logic                 frame_end;
    } parsed_item_t;

    logic clk = 1'b0;
    logic rst_n;

    shfp_byte_if stream_if ();
    shfp_item_if item_if ();
    shfp_cfg_if  cfg_if ();

    sync_header_frame_parser
    #(
        .ID_BYTES   (ID_BYTES),
        .NAME_BYTES (NAME_BYTES)
    )
    uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if.sink),
        .result (item_if.source),
        .cfg    (cfg_if.sink)
    );

    always #5ns clk = ~clk;

    // shadow copy of the parser state and its one register
    shfp_pkg::phase_t parse_phase = shfp_pkg::PH_HUNT;
    logic [2:0]  sync_seen   = '0;
    logic [15:0] field_count = '0;   // counts up through id and name, down through the body
    logic [7:0]  len_high    = '0;
    logic [15:0] max_len     = RESET_MAX_LEN;

    parsed_item_t expected_items[$];

    int unsigned error_count = 0;
    int unsigned words_sent  = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_hold  = 0;
    bit          idling      = 1'b1;    // random gaps and stalls on both sides

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic void push_expected(input shfp_pkg::item_kind_t kind,
                                          input logic [15:0] value,
                                          input logic frame_end);
        parsed_item_t item;
        item.kind      = kind;
        item.value     = value;
        item.frame_end = frame_end;
        expected_items.push_back(item);
    endfunction

    function automatic void return_to_hunt();
        parse_phase = shfp_pkg::PH_HUNT;
        sync_seen   = '0;
        field_count = '0;
    endfunction

    // advance the shadow parser by one accepted word
    function automatic void parse_word(input logic [7:0] b);
        logic [15:0] body_len;
        body_len = {len_high, b};
        case (parse_phase)
            shfp_pkg::PH_HUNT:
            begin
                // any other word breaks the sync run
                if (b != shfp_pkg::SYNC_BYTE)
                    sync_seen = '0;
                else if (sync_seen == 3'(SYNC_RUN - 1))
                begin
                    sync_seen   = '0;
                    field_count = '0;
                    parse_phase = shfp_pkg::PH_ID;
                end
                else
                    sync_seen = sync_seen + 3'd1;
            end
            shfp_pkg::PH_ID:
            begin
                push_expected(shfp_pkg::KIND_ID, {8'h00, b}, 1'b0);
                field_count = field_count + 16'd1;
                if (field_count >= ID_BYTES)
                begin
                    field_count = '0;
                    parse_phase = shfp_pkg::PH_NAME;
                end
            end
            shfp_pkg::PH_NAME:
            begin
                push_expected(shfp_pkg::KIND_NAME, {8'h00, b}, 1'b0);
                field_count = field_count + 16'd1;
                if (field_count >= NAME_BYTES)
                begin
                    field_count = '0;
                    parse_phase = shfp_pkg::PH_TYPE;
                end
            end
            shfp_pkg::PH_TYPE:
            begin
                push_expected(shfp_pkg::KIND_TYPE, {8'h00, b}, 1'b0);
                parse_phase = shfp_pkg::PH_RSVD;
            end
            // reserved word and length high word give nothing
            shfp_pkg::PH_RSVD:
                parse_phase = shfp_pkg::PH_LENH;
            shfp_pkg::PH_LENH:
            begin
                len_high    = b;
                parse_phase = shfp_pkg::PH_LENL;
            end
            shfp_pkg::PH_LENL:
            begin
                if (body_len > max_len)
                begin
                    return_to_hunt();
                    push_expected(shfp_pkg::KIND_LEN_ERR, body_len, 1'b1);
                end
                else if (body_len == 16'd0)
                begin
                    // empty body: the length result closes the frame
                    return_to_hunt();
                    push_expected(shfp_pkg::KIND_LENGTH, 16'd0, 1'b1);
                end
                else
                begin
                    field_count = body_len;
                    parse_phase = shfp_pkg::PH_BODY;
                    push_expected(shfp_pkg::KIND_LENGTH, body_len, 1'b0);
                end
            end
            default:
            begin
                if (field_count <= 16'd1)
                begin
                    return_to_hunt();
                    push_expected(shfp_pkg::KIND_BODY, {8'h00, b}, 1'b1);
                end
                else
                begin
                    field_count = field_count - 16'd1;
                    push_expected(shfp_pkg::KIND_BODY, {8'h00, b}, 1'b0);
                end
            end
        endcase
    endfunction

    // send one word, with an occasional random gap in front of it
    task automatic send_word(input logic [7:0] b);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            stream_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= b;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        parse_word(b);
        words_sent++;
    endtask

    // drop valid and wait until every expected result is out
    task automatic wait_idle();
        stream_if.valid <= 1'b0;
        while (expected_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // call only after wait_idle
    task automatic write_max_len(input logic [15:0] value);
        cfg_if.valid        <= 1'b1;
        cfg_if.max_body_len <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        max_len = value;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] fill_word(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] random_non_sync();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == shfp_pkg::SYNC_BYTE)
            b = ~b;
        return b;
    endfunction

    // sync run through the length words
    task automatic send_header(input logic [15:0] body_len, input fill_t fill);
        repeat (SYNC_RUN) send_word(shfp_pkg::SYNC_BYTE);
        // id, name, type and reserved word
        repeat (ID_BYTES + NAME_BYTES + 2) send_word(fill_word(fill));
        send_word(body_len[15:8]);
        send_word(body_len[7:0]);
    endtask

    // whole frame from sync run to last body word
    task automatic send_frame(input logic [15:0] body_len, input fill_t fill);
        send_header(body_len, fill);
        if (body_len <= max_len)
            repeat (body_len) send_word(fill_word(fill));
    endtask

    // broken sync runs, and a fifth sync word taken as the first id word
    task automatic test_sync_hunt();
        repeat (3) send_word(shfp_pkg::SYNC_BYTE);
        send_word(8'h00);
        repeat (2) send_word(shfp_pkg::SYNC_BYTE);
        send_word(8'hFF);
        repeat (SYNC_RUN + 1) send_word(shfp_pkg::SYNC_BYTE);
        repeat (ID_BYTES - 1 + NAME_BYTES + 2) send_word(8'hA5);
        send_word(8'h00);
        send_word(8'h01);
        send_word(8'h5A);
    endtask

    // all-zero and all-one field contents
    task automatic test_field_extremes();
        send_frame(16'd1, FILL_ZERO);
        send_frame(16'd2, FILL_ONES);
    endtask

    task automatic test_zero_length();
        send_frame(16'd0, FILL_RANDOM);
    endtask

    // reset value of the limit: one above it fails, short bodies pass
    task automatic test_reset_limit();
        send_frame(16'd24, FILL_RANDOM);
        send_frame(RESET_MAX_LEN + 16'd1, FILL_RANDOM);
        send_frame(16'hFFFF, FILL_RANDOM);
    endtask

    task automatic test_limit_settings();
        wait_idle();
        // limit zero: only an empty body passes
        write_max_len(16'd0);
        send_frame(16'd0, FILL_RANDOM);
        send_frame(16'd1, FILL_RANDOM);
        send_frame(16'h8000, FILL_RANDOM);
        wait_idle();
        write_max_len(16'd5);
        send_frame(16'd5, FILL_RANDOM);
        send_frame(16'd6, FILL_RANDOM);
        send_frame(16'h0100, FILL_RANDOM);
    endtask

    // mostly well-formed frames, some noise and broken sync runs
    task automatic test_random_frames();
        int unsigned start_count;
        int unsigned pick;
        int unsigned run;
        logic [7:0]  b;
        logic [15:0] body_len;
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_max_len(16'd0);
            else if (pick == 1)
                write_max_len(16'hFFFF);
            else if (pick == 2)
                write_max_len(16'($urandom_range(0, 16'hFFFF)));
            else
                write_max_len(16'($urandom_range(1, 40)));
            idling = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8))
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    // noise: never a full sync run, so later frames stay aligned
                    run = 0;
                    repeat ($urandom_range(1, 6))
                    begin
                        b = ($urandom_range(0, 3) == 0) ? shfp_pkg::SYNC_BYTE
                                                        : 8'($urandom_range(0, 255));
                        if (b == shfp_pkg::SYNC_BYTE && run == SYNC_RUN - 1)
                            b = random_non_sync();
                        run = (b == shfp_pkg::SYNC_BYTE) ? run + 1 : 0;
                        send_word(b);
                    end
                    send_word(random_non_sync());
                end
                else if (pick == 1)
                begin
                    repeat ($urandom_range(1, SYNC_RUN - 1)) send_word(shfp_pkg::SYNC_BYTE);
                    send_word(random_non_sync());
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        body_len = 16'd0;
                    else if (pick <= 2 && max_len != 16'hFFFF)
                        body_len = 16'($urandom_range(32'(max_len) + 1, 16'hFFFF));
                    else if (pick == 3 && max_len != 16'd0 && max_len <= 16'd48)
                        body_len = max_len;
                    else if (max_len == 16'd0)
                        body_len = 16'($urandom_range(1, 16'hFFFF));
                    else
                        body_len = 16'($urandom_range(1, (max_len < 16'd24) ? max_len : 24));
                    send_frame(body_len, FILL_RANDOM);
                end
            end
        end
    endtask

    // largest limit and largest length, no idling from here on
    task automatic test_full_length();
        idling = 1'b0;
        wait_idle();
        write_max_len(16'hFFFF);
        send_frame(16'd0, FILL_RANDOM);
        // longest length is accepted; the run ends partway through its body
        send_header(16'hFFFF, FILL_RANDOM);
        repeat (LONG_BODY_PART) send_word(fill_word(FILL_RANDOM));
    endtask

    // result side: random stall bursts while idling is set
    always @(posedge clk)
    begin
        if (!idling)
            item_if.ready <= 1'b1;
        else if (ready_hold != 0)
        begin
            ready_hold    <= ready_hold - 1;
            item_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            ready_hold    <= $urandom_range(0, 7);
            item_if.ready <= 1'b0;
        end
        else
            item_if.ready <= 1'b1;
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        parsed_item_t want;
        if (rst_n === 1'b1 && item_if.valid === 1'b1 && item_if.ready === 1'b1)
        begin
            if (expected_items.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d value %h",
                                          item_if.item_kind, item_if.item_value));
            else
            begin
                want = expected_items.pop_front();
                if (item_if.item_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              item_if.item_kind, want.kind));
                if (item_if.item_value !== want.value)
                    report_mismatch($sformatf("value %h, expected %h",
                                              item_if.item_value, want.value));
                if (item_if.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, expected %b (kind %0d)",
                                              item_if.frame_end, want.frame_end, want.kind));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // every input known from time zero
        rst_n               <= 1'b0;
        stream_if.valid     <= 1'b0;
        stream_if.data_byte <= 8'h00;
        cfg_if.valid        <= 1'b0;
        cfg_if.max_body_len <= 16'h0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_sync_hunt();
        test_field_extremes();
        test_zero_length();
        test_reset_limit();
        test_limit_settings();
        test_random_frames();
        test_full_length();

        // drain, then let the pipeline settle
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
